// ===== rtl/crh_pkg.sv =====
// shared types and constants for the cytosine retention histogram
package crh_pkg;

  // base codes
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  // context filter codes
  localparam logic [2:0] CTX_C   = 3'd0;
  localparam logic [2:0] CTX_CG  = 3'd1;
  localparam logic [2:0] CTX_CH  = 3'd2;
  localparam logic [2:0] CTX_HCG = 3'd3;
  localparam logic [2:0] CTX_GCH = 3'd4;
  localparam logic [2:0] CTX_HCH = 3'd5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CONTEXT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_SECONDARY = 1'd1;

  // queue between classifier and counter stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CLS_CONVERTED    = 2'd0,
    CLS_RETAINED     = 2'd1,
    CLS_UNDETERMINED = 2'd2
  } cls_t;

  typedef struct packed {
    logic [2:0] target_context;
    logic       drop_secondary;
  } cfg_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_sts_t;

  typedef struct packed {
    logic clearing;
  } back_sts_t;

endpackage

// ===== rtl/crh_front.sv =====
// classifier: read filters, strand and context check, class and position
module crh_front #(
  parameter int POSITION_LIMIT = 127,
  parameter int AW             = 10
) (
  input  crh_pkg::cfg_t    cfg,
  input  logic             is_unmapped,
  input  logic             is_secondary,
  input  logic             is_mate_two,
  input  logic             is_reverse,
  input  logic             bisulfite_reverse,
  input  logic [2:0]       reference_base,
  input  logic [2:0]       read_base,
  input  logic [2:0]       context_before,
  input  logic [2:0]       context_after,
  input  logic [15:0]      read_offset,
  input  logic [15:0]      read_length,
  output logic             keep,
  output logic [AW-1:0]    key
);
  import crh_pkg::*;

  localparam int PW = AW - 3;

  logic        strand_ok;
  logic        next_g;
  logic        prev_g;
  logic        ctx_ok;
  cls_t        cls;
  logic [16:0] pos_full;
  logic        in_range;

  assign strand_ok = bisulfite_reverse ? (reference_base == BASE_G)
                                       : (reference_base == BASE_C);
  assign next_g = (context_after == BASE_G);
  assign prev_g = (context_before == BASE_G);

  always_comb begin
    unique case (cfg.target_context)
      CTX_C:   ctx_ok = 1'b1;
      CTX_CG:  ctx_ok = next_g;
      CTX_CH:  ctx_ok = !next_g;
      CTX_HCG: ctx_ok = next_g && !prev_g;
      CTX_GCH: ctx_ok = !next_g && prev_g;
      CTX_HCH: ctx_ok = !next_g && !prev_g;
      default: ctx_ok = 1'b0;
    endcase
  end

  // g side: g kept, a converted; c side: c kept, t converted
  always_comb begin
    priority if (bisulfite_reverse ? (read_base == BASE_G) : (read_base == BASE_C)) begin
      cls = CLS_RETAINED;
    end else if (bisulfite_reverse ? (read_base == BASE_A) : (read_base == BASE_T)) begin
      cls = CLS_CONVERTED;
    end else begin
      cls = CLS_UNDETERMINED;
    end
  end

  // bit 16 set means a negative position on a reverse read
  assign pos_full = is_reverse ? ({1'b0, read_length} - {1'b0, read_offset})
                               : {1'b0, read_offset};
  assign in_range = !pos_full[16] && (pos_full[15:0] <= 16'(POSITION_LIMIT));

  assign keep = !is_unmapped && !(cfg.drop_secondary && is_secondary)
                && strand_ok && ctx_ok && in_range;
  assign key  = {is_mate_two, pos_full[PW-1:0], cls};

endmodule

// ===== rtl/crh_queue.sv =====
// short item queue between classifier and counter stage
module crh_queue #(
  parameter int W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [W-1:0]     push_data,
  input  logic             pop,
  output logic [W-1:0]     head,
  output crh_pkg::q_sts_t  sts
);
  import crh_pkg::*;

  logic [W-1:0]      buf_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= push_data;
    end
  end

  assign head          = buf_r[rptr_r];
  assign sts.not_empty = (cnt_r != '0);
  assign sts.full      = (cnt_r == QCNT_W'(QDEPTH));

endmodule

// ===== rtl/crh_back.sv =====
// counter stage: histogram memory, read-modify-write with forwarding, output register
module crh_back #(
  parameter int AW         = 10,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crh_pkg::q_sts_t     q_sts,
  input  logic [AW-1:0]       q_head,
  output logic                q_pop,
  output crh_pkg::back_sts_t  sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_mate_index,
  output logic [6:0]          out_position_index,
  output logic [1:0]          out_retention_class,
  output logic [31:0]         out_count_after
);
  import crh_pkg::*;

  localparam int PW    = AW - 3;
  localparam int DEPTH = 2 ** AW;

  logic [COUNT_BITS-1:0] hist_mem [DEPTH];

  logic                  clear_r;
  logic [AW-1:0]         clr_addr_r;
  logic                  s1_vld_r;
  logic                  s1_vld_nxt;
  logic [AW-1:0]         s1_addr_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  wlast_vld_r;
  logic [AW-1:0]         wlast_addr_r;
  logic [COUNT_BITS-1:0] wlast_val_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_mate_r;
  logic [6:0]            out_pos_r;
  logic [1:0]            out_cls_r;
  logic [31:0]           out_count_r;

  logic                       out_adv;
  logic                       s1_go;
  logic [COUNT_BITS-1:0]      cur;
  logic [COUNT_BITS-1:0]      inc;
  logic [COUNT_BITS+31:0]     inc_ext;
  logic [PW+6:0]              pos_ext;

  assign out_adv = !out_valid_r || !out_stall;
  assign s1_go   = s1_vld_r && out_adv;
  assign q_pop   = q_sts.not_empty && !clear_r && (!s1_vld_r || out_adv);

  // the last write may not be in the read data yet
  assign cur     = (wlast_vld_r && (wlast_addr_r == s1_addr_r)) ? wlast_val_r : rdata_r;
  assign inc     = (&cur) ? cur : cur + 1'b1;
  assign inc_ext = {32'b0, inc};
  assign pos_ext = {7'b0, s1_addr_r[AW-2:2]};

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (q_pop) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    out_valid_nxt = s1_go || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r     <= 1'b1;
      clr_addr_r  <= '0;
      s1_vld_r    <= 1'b0;
      wlast_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clear_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clear_r <= 1'b0;
        end
      end
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        wlast_vld_r <= 1'b1;
      end
    end
  end

  // histogram memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clear_r) begin
      hist_mem[clr_addr_r] <= '0;
    end else if (s1_go) begin
      hist_mem[s1_addr_r] <= inc;
    end
    if (q_pop) begin
      rdata_r <= hist_mem[q_head];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_addr_r <= q_head;
    end
    if (s1_go) begin
      wlast_addr_r <= s1_addr_r;
      wlast_val_r  <= inc;
      out_mate_r   <= s1_addr_r[AW-1];
      out_pos_r    <= pos_ext[6:0];
      out_cls_r    <= s1_addr_r[1:0];
      out_count_r  <= inc_ext[31:0];
    end
  end

  assign sts.clearing        = clear_r;
  assign out_valid           = out_valid_r;
  assign out_mate_index      = out_mate_r;
  assign out_position_index  = out_pos_r;
  assign out_retention_class = out_cls_r;
  assign out_count_after     = out_count_r;

endmodule

// ===== rtl/cytosine_retention_histogram.sv =====
// top level of the cytosine retention histogram
//
// usage:
//   in_* carries one aligned read base per item under valid/stall; out_* carries
//   one item per counted base: mate, position in read orientation, class and
//   the saturating count after the increment. bases that fail the mapping,
//   secondary, strand, context or position filters produce no output item.
//   cfg_we/cfg_index/cfg_wdata write target_context (index 0) and the
//   secondary-read skip (index 1); write only while the block is idle.
// pipeline and throughput:
//   a kept base goes through the queue, the read stage and the output register
//   before it shows on out_valid; one item per cycle is sustained while out_stall
//   is low, set by the histogram read-modify-write (one read and one write port),
//   which forwards the previous write so repeated keys need no bubble.
// reset:
//   rst_n clears the control state and starts a clearing pass over the
//   histogram memory of 2^(clog2(POSITION_LIMIT+1)+3) counters, one a cycle;
//   in_stall is held high until it ends.
// stall:
//   a stalled output item holds; a four-entry queue keeps input items coming
//   until it fills, then in_stall rises.
module cytosine_retention_histogram #(
  parameter int POSITION_LIMIT = 127,
  parameter int COUNT_BITS     = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [crh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_is_unmapped,
  input  logic                           in_is_secondary,
  input  logic                           in_is_mate_two,
  input  logic                           in_is_reverse,
  input  logic                           in_bisulfite_reverse,
  input  logic [2:0]                     in_reference_base,
  input  logic [2:0]                     in_read_base,
  input  logic [2:0]                     in_context_before,
  input  logic [2:0]                     in_context_after,
  input  logic [15:0]                    in_read_offset,
  input  logic [15:0]                    in_read_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_mate_index,
  output logic [6:0]                     out_position_index,
  output logic [1:0]                     out_retention_class,
  output logic [31:0]                    out_count_after
);
  import crh_pkg::*;

  localparam int PW = $clog2(POSITION_LIMIT + 1);
  localparam int AW = PW + 3;

  cfg_t          cfg_r;
  logic          keep;
  logic [AW-1:0] key;
  logic          q_push;
  logic          q_pop;
  logic [AW-1:0] q_head;
  q_sts_t        q_sts;
  back_sts_t     back_sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_context <= CTX_CG;
      cfg_r.drop_secondary <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_CONTEXT: cfg_r.target_context <= cfg_wdata;
        REG_DROP_SECONDARY: cfg_r.drop_secondary <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  crh_front #(
    .POSITION_LIMIT (POSITION_LIMIT),
    .AW             (AW)
  ) u_front (
    .cfg               (cfg_r),
    .is_unmapped       (in_is_unmapped),
    .is_secondary      (in_is_secondary),
    .is_mate_two       (in_is_mate_two),
    .is_reverse        (in_is_reverse),
    .bisulfite_reverse (in_bisulfite_reverse),
    .reference_base    (in_reference_base),
    .read_base         (in_read_base),
    .context_before    (in_context_before),
    .context_after     (in_context_after),
    .read_offset       (in_read_offset),
    .read_length       (in_read_length),
    .keep              (keep),
    .key               (key)
  );

  assign in_stall = back_sts.clearing || q_sts.full;
  assign q_push   = in_valid && !in_stall && keep;

  crh_queue #(
    .W (AW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (key),
    .pop       (q_pop),
    .head      (q_head),
    .sts       (q_sts)
  );

  crh_back #(
    .AW         (AW),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_sts               (q_sts),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .sts                 (back_sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mate_index      (out_mate_index),
    .out_position_index  (out_position_index),
    .out_retention_class (out_retention_class),
    .out_count_after     (out_count_after)
  );

  // nothing leaves the block before the histogram is cleared
  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    back_sts.clearing |-> !out_valid)
    else $error("output item during clearing pass");

  // a counted base always leaves a non-zero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count_after != 32'd0))
    else $error("zero count on output item");

  a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_retention_class == CLS_CONVERTED ||
                   out_retention_class == CLS_RETAINED ||
                   out_retention_class == CLS_UNDETERMINED))
    else $error("illegal retention class on output item");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the cytosine retention histogram
module testbench;
  import crh_pkg::*;

  localparam int POSITION_LIMIT = 127;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_GAP        = 13;

  // context and base codes with no meaning, they must match nothing
  localparam logic [2:0] CTX_UNUSED_6 = 3'd6;
  localparam logic [2:0] CTX_UNUSED_7 = 3'd7;
  localparam logic [2:0] BASE_OTHER   = 3'd4;
  localparam logic [2:0] BASE_CODE_7  = 3'd7;

  typedef struct packed {
    logic        is_unmapped;
    logic        is_secondary;
    logic        is_mate_two;
    logic        is_reverse;
    logic        bisulfite_reverse;
    logic [2:0]  reference_base;
    logic [2:0]  read_base;
    logic [2:0]  context_before;
    logic [2:0]  context_after;
    logic [15:0] read_offset;
    logic [15:0] read_length;
  } base_t;

  typedef struct packed {
    logic        mate;
    logic [6:0]  pos;
    cls_t        cls;
    logic [31:0] count;
  } count_t;

  class retention_book;
    logic [31:0] tally [2][POSITION_LIMIT+1][3];
    logic [2:0]  target_ctx;
    logic        skip_sec;
    count_t      awaited_counts[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned bases_noted;

    function new();
      foreach (tally[m, p, c]) tally[m][p][c] = '0;
      target_ctx   = CTX_CG;
      skip_sec     = 1'b1;
      mismatches   = 0;
      results_seen = 0;
      bases_noted  = 0;
    endfunction

    function void set_config(logic [2:0] ctx, logic skip);
      target_ctx = ctx;
      skip_sec   = skip;
    endfunction

    function int pending();
      return awaited_counts.size();
    endfunction

    function bit context_ok(base_t b);
      bit next_g;
      bit prev_g;
      next_g = (b.context_after == BASE_G);
      prev_g = (b.context_before == BASE_G);
      case (target_ctx)
        CTX_C:   return 1'b1;
        CTX_CG:  return next_g;
        CTX_CH:  return !next_g;
        CTX_HCG: return next_g && !prev_g;
        CTX_GCH: return !next_g && prev_g;
        CTX_HCH: return !next_g && !prev_g;
        default: return 1'b0;
      endcase
    endfunction

    // works out the count that an accepted base leads to, if any
    function void note_base(base_t b);
      logic [16:0] span;
      cls_t        cls;
      count_t      want;
      bases_noted++;
      if (b.is_unmapped) return;
      if (skip_sec && b.is_secondary) return;
      if (b.bisulfite_reverse ? (b.reference_base != BASE_G) : (b.reference_base != BASE_C))
        return;
      if (!context_ok(b)) return;
      if (b.bisulfite_reverse) begin
        if (b.read_base == BASE_G) cls = CLS_RETAINED;
        else if (b.read_base == BASE_A) cls = CLS_CONVERTED;
        else cls = CLS_UNDETERMINED;
      end else begin
        if (b.read_base == BASE_C) cls = CLS_RETAINED;
        else if (b.read_base == BASE_T) cls = CLS_CONVERTED;
        else cls = CLS_UNDETERMINED;
      end
      if (b.is_reverse) begin
        if (b.read_length < b.read_offset) return;
        span = {1'b0, b.read_length} - {1'b0, b.read_offset};
      end else begin
        span = {1'b0, b.read_offset};
      end
      if (span > POSITION_LIMIT) return;
      if (tally[b.is_mate_two][span[6:0]][int'(cls)] != '1)
        tally[b.is_mate_two][span[6:0]][int'(cls)]++;
      want.mate  = b.is_mate_two;
      want.pos   = span[6:0];
      want.cls   = cls;
      want.count = tally[b.is_mate_two][span[6:0]][int'(cls)];
      awaited_counts.push_back(want);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch %0d at %0t: %s", mismatches, $time, what);
    endtask

    task check_result(count_t got);
      count_t want;
      results_seen++;
      if (awaited_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected item mate %0d pos %0d class %0d count %0d",
                                  got.mate, got.pos, got.cls, got.count));
        return;
      end
      want = awaited_counts.pop_front();
      if (got.mate != want.mate)
        report_mismatch($sformatf("mate_index %0d, want %0d", got.mate, want.mate));
      if (got.pos != want.pos)
        report_mismatch($sformatf("position_index %0d, want %0d", got.pos, want.pos));
      if (got.cls != want.cls)
        report_mismatch($sformatf("retention_class %0d, want %0d", got.cls, want.cls));
      if (got.count != want.count)
        report_mismatch($sformatf("count_after %0d, want %0d", got.count, want.count));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_is_unmapped;
  logic                  in_is_secondary;
  logic                  in_is_mate_two;
  logic                  in_is_reverse;
  logic                  in_bisulfite_reverse;
  logic [2:0]            in_reference_base;
  logic [2:0]            in_read_base;
  logic [2:0]            in_context_before;
  logic [2:0]            in_context_after;
  logic [15:0]           in_read_offset;
  logic [15:0]           in_read_length;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_mate_index;
  logic [6:0]            out_position_index;
  logic [1:0]            out_retention_class;
  logic [31:0]           out_count_after;

  retention_book book = new();
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  bit rx_hold_req = 1'b0;
  int settings_run = 0;

  cytosine_retention_histogram DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_is_unmapped       (in_is_unmapped),
    .in_is_secondary      (in_is_secondary),
    .in_is_mate_two       (in_is_mate_two),
    .in_is_reverse        (in_is_reverse),
    .in_bisulfite_reverse (in_bisulfite_reverse),
    .in_reference_base    (in_reference_base),
    .in_read_base         (in_read_base),
    .in_context_before    (in_context_before),
    .in_context_after     (in_context_after),
    .in_read_offset       (in_read_offset),
    .in_read_length       (in_read_length),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_mate_index       (out_mate_index),
    .out_position_index   (out_position_index),
    .out_retention_class  (out_retention_class),
    .out_count_after      (out_count_after)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic base_t make_base(int unm, int sec, int mate, int rev, int bs,
                                      logic [2:0] rbase, logic [2:0] rd, logic [2:0] bef,
                                      logic [2:0] aft, logic [15:0] off, logic [15:0] len);
    base_t b;
    b = '{1'(unm), 1'(sec), 1'(mate), 1'(rev), 1'(bs), rbase, rd, bef, aft, off, len};
    return b;
  endfunction

  // mostly mapped bases of the right strand in or near the position range, the rest raw noise
  function automatic base_t random_base();
    base_t       b;
    int unsigned pos;
    b.is_unmapped       = 1'($urandom_range(0, 1));
    b.is_secondary      = 1'($urandom_range(0, 1));
    b.is_mate_two       = 1'($urandom_range(0, 1));
    b.is_reverse        = 1'($urandom_range(0, 1));
    b.bisulfite_reverse = 1'($urandom_range(0, 1));
    b.reference_base    = 3'($urandom_range(0, 7));
    b.read_base         = 3'($urandom_range(0, 7));
    b.context_before    = 3'($urandom_range(0, 7));
    b.context_after     = 3'($urandom_range(0, 7));
    b.read_offset       = 16'($urandom_range(0, 65535));
    b.read_length       = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 80) begin
      b.is_unmapped    = ($urandom_range(0, 19) == 0);
      b.reference_base = b.bisulfite_reverse ? BASE_G : BASE_C;
      if ($urandom_range(0, 9) < 7) b.read_base = 3'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) b.context_after = BASE_G;
      if ($urandom_range(0, 2) == 0) b.context_before = BASE_G;
      // a few hot positions so that the same counter is hit back to back
      pos = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3)
                                        : $urandom_range(0, POSITION_LIMIT + 2);
      if (b.is_reverse) begin
        b.read_offset = 16'($urandom_range(0, 65535 - pos));
        b.read_length = 16'(b.read_offset + pos);
      end else begin
        b.read_offset = 16'(pos);
      end
    end
    return b;
  endfunction

  task automatic send_base(input base_t b);
    int gap;
    gap = tx_calm ? 0 : int'($urandom_range(0, MAX_GAP));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_is_unmapped       <= b.is_unmapped;
    in_is_secondary      <= b.is_secondary;
    in_is_mate_two       <= b.is_mate_two;
    in_is_reverse        <= b.is_reverse;
    in_bisulfite_reverse <= b.bisulfite_reverse;
    in_reference_base    <= b.reference_base;
    in_read_base         <= b.read_base;
    in_context_before    <= b.context_before;
    in_context_after     <= b.context_after;
    in_read_offset       <= b.read_offset;
    in_read_length       <= b.read_length;
    in_valid             <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_base(b);
  endtask

  task automatic write_config(input logic [2:0] ctx, input logic skip);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TARGET_CONTEXT;
    cfg_wdata <= ctx;
    @(posedge clk);
    cfg_index <= REG_DROP_SECONDARY;
    cfg_wdata <= {2'b00, skip};
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_config(ctx, skip);
  endtask

  // sender stops until every awaited count is back, then lets the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [2:0] ctx, input logic skip, input int n,
                           input bit quiet_tx, input bit quiet_rx, input bit squeeze);
    drain();
    write_config(ctx, skip);
    tx_calm = quiet_tx;
    rx_calm = quiet_rx;
    if (squeeze) rx_hold_req = 1'b1;
    repeat (n) send_base(random_base());
    settings_run++;
  endtask

  // result side: random stall per item, long hold-off on request
  initial begin
    int unsigned hold;
    count_t      got;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.mate  = out_mate_index;
        got.pos   = out_position_index;
        got.cls   = cls_t'(out_retention_class);
        got.count = out_count_after;
        book.check_result(got);
        hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    base_t plan[$];
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    in_valid             <= 1'b0;
    in_is_unmapped       <= 1'b0;
    in_is_secondary      <= 1'b0;
    in_is_mate_two       <= 1'b0;
    in_is_reverse        <= 1'b0;
    in_bisulfite_reverse <= 1'b0;
    in_reference_base    <= '0;
    in_read_base         <= '0;
    in_context_before    <= '0;
    in_context_after     <= '0;
    in_read_offset       <= '0;
    in_read_length       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // forward strand classes, repeated key, position edges
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'd0, 16'd50));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, BASE_C, BASE_A, BASE_G, 16'd0, 16'd50));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, BASE_T, BASE_G, BASE_A, 16'd0, 16'd50));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, BASE_A, BASE_T, BASE_C, 16'd127, 16'd0));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'd128, 16'd200));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'hFFFF, 16'd0));
    // reverse reads: zero, top, above-range and negative positions
    plan.push_back(make_base(0, 0, 0, 1, 0, BASE_C, BASE_C, BASE_A, BASE_A, 16'd10, 16'd10));
    plan.push_back(make_base(0, 0, 1, 1, 0, BASE_C, BASE_C, BASE_A, BASE_A, 16'hFFFF, 16'hFFFF));
    plan.push_back(make_base(0, 0, 0, 1, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'd0, 16'd127));
    plan.push_back(make_base(0, 0, 0, 1, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'd0, 16'd128));
    plan.push_back(make_base(0, 0, 0, 1, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'd11, 16'd10));
    plan.push_back(make_base(0, 0, 0, 1, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'd0, 16'hFFFF));
    // G side of the bisulfite strand
    plan.push_back(make_base(0, 0, 0, 0, 1, BASE_G, BASE_G, BASE_A, BASE_A, 16'd5, 16'd9));
    plan.push_back(make_base(0, 0, 0, 0, 1, BASE_G, BASE_A, BASE_A, BASE_A, 16'd5, 16'd9));
    plan.push_back(make_base(0, 0, 0, 0, 1, BASE_G, BASE_CODE_7, BASE_A, BASE_A, 16'd5, 16'd9));
    // wrong strand, odd base codes, unmapped, secondary and a mate-two base
    plan.push_back(make_base(0, 0, 0, 0, 1, BASE_C, BASE_G, BASE_A, BASE_A, 16'd5, 16'd9));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_G, BASE_C, BASE_A, BASE_A, 16'd5, 16'd9));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_CODE_7, BASE_C, BASE_A, BASE_A, 16'd5, 16'd9));
    plan.push_back(make_base(1, 0, 0, 0, 0, BASE_C, BASE_C, BASE_A, BASE_A, 16'd5, 16'd9));
    plan.push_back(make_base(0, 1, 0, 0, 0, BASE_C, BASE_C, BASE_A, BASE_A, 16'd5, 16'd9));
    plan.push_back(make_base(0, 0, 1, 0, 0, BASE_C, BASE_T, BASE_A, BASE_A, 16'd64, 16'd9));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, 3'd5, BASE_OTHER, BASE_OTHER, 16'd3, 16'd9));
    plan.push_back(make_base(0, 0, 0, 0, 0, BASE_C, BASE_C, BASE_CODE_7, BASE_CODE_7, 16'd3,
                             16'd9));
    plan.push_back(make_base(0, 0, 1, 1, 1, BASE_G, BASE_CODE_7, BASE_CODE_7, BASE_CODE_7,
                             16'hFFFF, 16'hFFFF));

    write_config(CTX_C, 1'b1);
    foreach (plan[i]) send_base(plan[i]);
    settings_run++;

    run_phase(CTX_C,        1'b0, 200, 1'b0, 1'b0, 1'b0);
    run_phase(CTX_CG,       1'b1, 230, 1'b1, 1'b0, 1'b1);
    run_phase(CTX_CH,       1'b0, 230, 1'b0, 1'b1, 1'b0);
    run_phase(CTX_HCG,      1'b1, 230, 1'b1, 1'b1, 1'b0);
    run_phase(CTX_GCH,      1'b0, 230, 1'b0, 1'b0, 1'b0);
    run_phase(CTX_HCH,      1'b1, 230, 1'b0, 1'b0, 1'b0);
    run_phase(CTX_UNUSED_6, 1'b0, 30,  1'b0, 1'b0, 1'b0);
    run_phase(CTX_UNUSED_7, 1'b1, 30,  1'b1, 1'b1, 1'b0);
    run_phase(CTX_CG,       1'b0, 230, 1'b0, 1'b0, 1'b0);
    run_phase(CTX_HCH,      1'b0, 200, 1'b1, 1'b0, 1'b1);
    drain();

    $display("sent %0d bases under %0d filter settings (all eight context codes, both",
             book.bases_noted, settings_run);
    $display("secondary modes); %0d counts checked, %0d mismatches",
             book.results_seen, book.mismatches);
    if (book.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
